### rtl/threefish256_counter_rng_unit_defines.svh
// Assertion helpers used by the RTL queue.
`ifndef THREEFISH256_COUNTER_RNG_UNIT_DEFINES_SVH
`define THREEFISH256_COUNTER_RNG_UNIT_DEFINES_SVH

// Overlapping implication, checked outside reset.
`define TF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tf256_pkg.sv
package tf256_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned Rounds     = 20;
  localparam int unsigned KeyCount   = 4;
  localparam int unsigned CfgIdxW    = 3;

  localparam logic [63:0] KeyParity = 64'h1BD11BDAA9FC1A22;
  localparam logic [63:0] ResetKey0 = 64'hDEADBEEFDEADBEEF;

  typedef enum logic [1:0] {
    OP_GEN  = 2'd0,
    OP_SKIP = 2'd1,
    OP_LOAD = 2'd2
  } opcode_t;

  typedef logic [3:0][63:0] blk_t;

  typedef struct packed {
    blk_t       ctr;
    logic [2:0] slot;
  } req_t;

  typedef struct packed {
    logic               we;
    logic [CfgIdxW-1:0] index;
    logic [63:0]        data;
  } cfg_wr_t;

  function automatic logic [5:0] rot_amt(int unsigned d, int unsigned j);
    logic [5:0] a0;
    logic [5:0] a1;
    case (d % 8)
      0: begin a0 = 6'd14; a1 = 6'd16; end
      1: begin a0 = 6'd52; a1 = 6'd57; end
      2: begin a0 = 6'd23; a1 = 6'd40; end
      3: begin a0 = 6'd5;  a1 = 6'd37; end
      4: begin a0 = 6'd25; a1 = 6'd33; end
      5: begin a0 = 6'd46; a1 = 6'd12; end
      6: begin a0 = 6'd58; a1 = 6'd22; end
      default: begin a0 = 6'd32; a1 = 6'd32; end
    endcase
    return (j == 0) ? a0 : a1;
  endfunction

  // Rotation amounts are never zero.
  function automatic logic [63:0] rotl(logic [63:0] x, logic [5:0] r);
    return (x << r) | (x >> (7'd64 - {1'b0, r}));
  endfunction

  function automatic blk_t inject(blk_t b, blk_t sk, int unsigned s);
    blk_t o;
    for (int i = 0; i < 4; i++) o[i] = b[i] + sk[i];
    o[3] = o[3] + 64'(s);
    return o;
  endfunction

  function automatic blk_t mix_round(blk_t b, int unsigned d);
    blk_t o;
    o = b;
    if ((d % 2) == 0) begin
      o[0] = b[0] + b[1];
      o[1] = rotl(b[1], rot_amt(d, 0)) ^ o[0];
      o[2] = b[2] + b[3];
      o[3] = rotl(b[3], rot_amt(d, 1)) ^ o[2];
    end else begin
      o[0] = b[0] + b[3];
      o[3] = rotl(b[3], rot_amt(d, 0)) ^ o[0];
      o[2] = b[2] + b[1];
      o[1] = rotl(b[1], rot_amt(d, 1)) ^ o[2];
    end
    return o;
  endfunction

endpackage

### rtl/tf256_in_if.sv
interface tf256_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] skip_count;
  logic [63:0] position_word_0;
  logic [63:0] position_word_1;
  logic [63:0] position_word_2;
  logic [63:0] position_word_3;
  logic [2:0]  start_slot;

  modport source (output valid, opcode, skip_count, position_word_0, position_word_1,
                  position_word_2, position_word_3, start_slot, input ready);
  modport sink (input valid, opcode, skip_count, position_word_0, position_word_1,
                position_word_2, position_word_3, start_slot, output ready);
endinterface

### rtl/tf256_out_if.sv
interface tf256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source (output valid, random_word, input ready);
  modport sink (input valid, random_word, output ready);
endinterface

### rtl/tf256_front.sv
module tf256_front (
  input  logic              clk,
  input  logic              rst_n,
  tf256_in_if.sink          in_ch,
  input  logic              q_full,
  output logic              q_push,
  output tf256_pkg::req_t   q_req
);
  import tf256_pkg::*;

  blk_t        ctr_r, ctr_nxt;
  logic [3:0]  slot_r, slot_nxt;
  logic        acc;
  logic [3:0]  left;
  logic [63:0] zrem;
  logic [63:0] blocks;
  blk_t        ctr_inc;

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && !q_full;
  assign left        = 4'd8 - slot_r;
  assign zrem        = in_ch.skip_count - 64'(left);
  assign blocks      = {3'd0, zrem[63:3]} + 64'd1;
  assign ctr_inc     = ctr_r + 256'(1);

  always_comb begin
    ctr_nxt = ctr_r;
    slot_nxt = slot_r;
    q_push = 1'b0;
    q_req.ctr = ctr_r;
    q_req.slot = slot_r[2:0];
    if (acc) begin
      case (in_ch.opcode)
        OP_GEN: begin
          q_push = 1'b1;
          if (slot_r[3]) begin
            // block used up: advance to the next counter
            ctr_nxt = ctr_inc;
            q_req.ctr = ctr_inc;
            q_req.slot = 3'd0;
            slot_nxt = 4'd1;
          end else begin
            slot_nxt = slot_r + 4'd1;
          end
        end
        OP_SKIP: begin
          if (in_ch.skip_count < 64'(left)) begin
            slot_nxt = slot_r + in_ch.skip_count[3:0];
          end else begin
            slot_nxt = {1'b0, zrem[2:0]};
            ctr_nxt = ctr_r + 256'(blocks);
          end
        end
        OP_LOAD: begin
          ctr_nxt = {in_ch.position_word_3, in_ch.position_word_2,
                     in_ch.position_word_1, in_ch.position_word_0};
          slot_nxt = {1'b0, in_ch.start_slot};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= '0;
      slot_r <= 4'd0;
    end else begin
      ctr_r <= ctr_nxt;
      slot_r <= slot_nxt;
    end
  end

endmodule

### rtl/tf256_queue.sv
`include "threefish256_counter_rng_unit_defines.svh"

module tf256_queue #(
  parameter int unsigned DEPTH = tf256_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tf256_pkg::req_t  push_req,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output tf256_pkg::req_t  head_req
);
  import tf256_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  req_t            mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r;

  assign full       = (cnt_r == CntW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_req   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_req;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  `TF_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CntW'(DEPTH), "queue overfilled")
  `TF_ASSERT_IMP(a_pop_nonempty, clk, rst_n, pop, cnt_r != '0, "pop from empty queue")
  `TF_ASSERT_NXT(a_push_count, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + 1'b1,
                 "queue count did not grow")

endmodule

### rtl/tf256_back.sv
module tf256_back (
  input  logic              clk,
  input  logic              rst_n,
  input  tf256_pkg::cfg_wr_t cfg,
  input  logic              q_valid,
  input  tf256_pkg::req_t   q_head,
  output logic              q_pop,
  tf256_out_if.source       out_ch
);
  import tf256_pkg::*;

  logic [63:0]       key_r [KeyCount];
  logic [63:0]       ks [5];
  blk_t              stg_b_r [Rounds];
  logic [2:0]        stg_slot_r [Rounds];
  logic [Rounds-1:0] stg_vld_r;
  logic              adv;
  logic              out_valid_r;
  logic [31:0]       out_word_r;
  blk_t              fin_sk;
  blk_t              fin_b;
  logic [63:0]       sel_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0] <= ResetKey0;
      for (int i = 1; i < KeyCount; i++) key_r[i] <= '0;
    end else if (cfg.we && (cfg.index < CfgIdxW'(KeyCount))) begin
      key_r[cfg.index[1:0]] <= cfg.data;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) ks[i] = key_r[i];
    ks[4] = KeyParity ^ key_r[0] ^ key_r[1] ^ key_r[2] ^ key_r[3];
  end

  // Whole pipe holds while the output register is full and not taken.
  assign adv   = !out_valid_r || out_ch.ready;
  assign q_pop = adv && q_valid;

  for (genvar d = 0; d < Rounds; d++) begin : g_round
    blk_t       b_in;
    blk_t       sk;
    blk_t       b_inj;
    logic [2:0] s_in;
    logic       v_in;

    if (d == 0) begin : g_first
      assign b_in = q_head.ctr;
      assign s_in = q_head.slot;
      assign v_in = q_valid;
    end else begin : g_next
      assign b_in = stg_b_r[d-1];
      assign s_in = stg_slot_r[d-1];
      assign v_in = stg_vld_r[d-1];
    end

    for (genvar i = 0; i < 4; i++) begin : g_sk
      assign sk[i] = ks[(d / 4 + i) % 5];
    end

    if ((d % 4) == 0) begin : g_inj
      assign b_inj = inject(b_in, sk, d / 4);
    end else begin : g_noinj
      assign b_inj = b_in;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stg_b_r[d] <= mix_round(b_inj, d);
        stg_slot_r[d] <= s_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) stg_vld_r[d] <= 1'b0;
      else if (adv) stg_vld_r[d] <= v_in;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) fin_sk[i] = ks[(Rounds / 4 + i) % 5];
  end

  assign fin_b = inject(stg_b_r[Rounds-1], fin_sk, Rounds / 4);
  assign sel_w = fin_b[stg_slot_r[Rounds-1][2:1]];

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= stg_vld_r[Rounds-1];
  end

  always_ff @(posedge clk) begin
    if (adv) out_word_r <= stg_slot_r[Rounds-1][0] ? sel_w[63:32] : sel_w[31:0];
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.random_word = out_word_r;

endmodule

### rtl/threefish256_counter_rng_unit.sv
// Path: an accepted generate request is pushed into the queue; the queue head feeds round
//   stage 0, then round stages 1 to 19 in turn, then the output register; the whole pipe
//   holds while the output register is full and not taken.
// Throughput: one request per cycle while the queue is not full; one random word per cycle
//   while the output is taken, set by the fully pipelined Threefish-256 round chain.
// Reset: rst_n synchronous, active low; clears counter, word slot, queue, pipe valids
//   and loads the default key.
module threefish256_counter_rng_unit #(
  parameter int unsigned QUEUE_DEPTH = tf256_pkg::QueueDepth
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tf256_in_if.sink                      in_ch,
  tf256_out_if.source                   out_ch,
  input  logic                          cfg_we,
  input  logic [tf256_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0]                   cfg_wdata
);
  import tf256_pkg::*;

  // Front tracks counter and slot and issues one request per generated word;
  // skip and load only update its state. The back side encrypts each request's
  // counter on its own, so key writes and skips need no block refresh.
  logic    q_push, q_full, q_pop, q_valid;
  req_t    q_req, q_head;
  cfg_wr_t cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_wdata;

  tf256_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_req  (q_req)
  );

  // Decouple the command side from the cipher pipe.
  tf256_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_req   (q_req),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_req   (q_head)
  );

  // Hold the key, encrypt, pick the requested half word.
  tf256_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

### tb/sv/tf256_rng_checker.sv
module tf256_rng_checker
  import tf256_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  tf256_in_if                 in_mon,
  tf256_out_if                out_mon,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [63:0]         cfg_wdata,
  output int                  errors,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SlotsPerBlock = 8;
  localparam logic [5:0] RotA [8] = '{6'd14, 6'd52, 6'd23, 6'd5, 6'd25, 6'd46, 6'd58, 6'd32};
  localparam logic [5:0] RotB [8] = '{6'd16, 6'd57, 6'd40, 6'd37, 6'd33, 6'd12, 6'd22, 6'd32};

  blk_t         key;
  blk_t         ctr;
  blk_t         keystream;
  int unsigned  slot;
  logic [31:0]  word_q[$];

  function automatic logic [63:0] spin(logic [63:0] x, logic [5:0] n);
    return (x << n) | (x >> (7'd64 - {1'b0, n}));
  endfunction

  // Threefish-256 rounds, cut to Rounds rounds, zero tweak, subkey every fourth round and after the last.
  function automatic blk_t encipher(blk_t k, blk_t pt);
    logic [63:0] ks [5];
    blk_t v;
    int unsigned s;
    v = pt;
    for (int i = 0; i < 4; i++) ks[i] = k[i];
    ks[4] = KeyParity ^ k[0] ^ k[1] ^ k[2] ^ k[3];
    for (int unsigned r = 0; r <= Rounds; r++) begin
      if (r % 4 == 0) begin
        s = r / 4;
        for (int i = 0; i < 4; i++) v[i] = v[i] + ks[(s + i) % 5];
        v[3] = v[3] + 64'(s);
      end
      if (r == Rounds) break;
      if (r % 2 == 0) begin
        v[0] = v[0] + v[1];
        v[1] = spin(v[1], RotA[r % 8]) ^ v[0];
        v[2] = v[2] + v[3];
        v[3] = spin(v[3], RotB[r % 8]) ^ v[2];
      end else begin
        v[0] = v[0] + v[3];
        v[3] = spin(v[3], RotA[r % 8]) ^ v[0];
        v[2] = v[2] + v[1];
        v[1] = spin(v[1], RotB[r % 8]) ^ v[2];
      end
    end
    return v;
  endfunction

  assign pending = word_q.size();

  always @(posedge clk) begin
    logic [63:0] z;
    logic [63:0] w;
    if (!rst_n) begin
      key = '0;
      key[0] = ResetKey0;
      ctr = '0;
      slot = 0;
      keystream = encipher(key, ctr);
      word_q.delete();
      errors = 0;
    end else begin
      if (cfg_we && cfg_index < CfgIdxW'(KeyCount)) begin
        key[cfg_index] = cfg_wdata;
        keystream = encipher(key, ctr);
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.opcode)
          OP_GEN: begin
            if (slot >= SlotsPerBlock) begin
              ctr = ctr + 256'd1;
              keystream = encipher(key, ctr);
              slot = 0;
            end
            w = keystream[slot >> 1];
            word_q.push_back(slot[0] ? w[63:32] : w[31:0]);
            slot++;
          end
          OP_SKIP: begin
            z = in_mon.skip_count;
            if (z < 64'(SlotsPerBlock - slot)) begin
              slot = slot + int'(z);
            end else begin
              z = z - 64'(SlotsPerBlock - slot);
              slot = int'(z[2:0]);
              ctr = ctr + 256'(z >> 3) + 256'd1;
              keystream = encipher(key, ctr);
            end
          end
          OP_LOAD: begin
            ctr = {in_mon.position_word_3, in_mon.position_word_2,
                   in_mon.position_word_1, in_mon.position_word_0};
            slot = 32'(in_mon.start_slot);
            keystream = encipher(key, ctr);
          end
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (word_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: expected none, actual %h", $time,
                   out_mon.random_word);
        end else begin
          w[31:0] = word_q.pop_front();
          if (out_mon.random_word !== w[31:0]) begin
            errors++;
            $display("%0t: random_word mismatch: expected %h, actual %h", $time,
                     w[31:0], out_mon.random_word);
          end
        end
      end
    end
  end
endmodule

### tb/sv/tb_threefish256_counter_rng_unit.sv
module tb_threefish256_counter_rng_unit;
  import tf256_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcode the block must ignore, and a key index past the last register.
  localparam logic [1:0]         OpUnused     = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = CfgIdxW'(5);
  localparam int                 CycleLimit   = 300000;
  localparam int                 ItemsPerPhase = 233;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [63:0] cfg_wdata = '0;
  logic req_taken = 1'b0;
  int snd_idle = 0;
  int rcv_idle = 0;
  int errors;
  int pending;
  int cycles = 0;

  tf256_in_if  in_ch ();
  tf256_out_if out_ch ();

  threefish256_counter_rng_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  tf256_rng_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Latch the handshake at the edge so the driver never races the block.
  always @(posedge clk) req_taken <= in_ch.valid && in_ch.ready;

  // Bound the run; a hang shows up as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver backpressure, redrawn every cycle.
  always @(negedge clk) out_ch.ready = ($urandom_range(99) >= rcv_idle);

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Present one request and hold it until accepted; call just after a falling edge.
  task automatic send(logic [1:0] op, logic [63:0] skip, logic [63:0] p0,
                      logic [63:0] p1, logic [63:0] p2, logic [63:0] p3,
                      logic [2:0] slot);
    while ($urandom_range(99) < snd_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.opcode = op;
    in_ch.skip_count = skip;
    in_ch.position_word_0 = p0;
    in_ch.position_word_1 = p1;
    in_ch.position_word_2 = p2;
    in_ch.position_word_3 = p3;
    in_ch.start_slot = slot;
    do @(negedge clk); while (!req_taken);
  endtask

  task automatic gen(int n);
    for (int i = 0; i < n; i++) send(OP_GEN, rand64(), rand64(), rand64(), rand64(),
                                    rand64(), 3'($urandom));
  endtask

  task automatic skip(logic [63:0] n);
    send(OP_SKIP, n, rand64(), rand64(), rand64(), rand64(), 3'($urandom));
  endtask

  task automatic load(logic [255:0] pos, logic [2:0] slot);
    send(OP_LOAD, rand64(), pos[63:0], pos[127:64], pos[191:128], pos[255:192], slot);
  endtask

  // Drain every outstanding word, then let the cipher pipe empty out.
  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  // Key writes only while the block is quiet.
  task automatic write_key(logic [CfgIdxW-1:0] idx, logic [63:0] value);
    drain();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_request();
    int r;
    logic [63:0] n;
    r = $urandom_range(99);
    if (r < 55) begin
      gen(1);
    end else if (r < 78) begin
      r = $urandom_range(9);
      if (r < 7) n = 64'($urandom_range(20));
      else if (r < 9) n = {32'h0, $urandom};
      else n = rand64();
      skip(n);
    end else if (r < 92) begin
      load({rand64(), rand64(), rand64(), rand64()}, 3'($urandom));
    end else if (r < 95) begin
      send(OpUnused, rand64(), rand64(), rand64(), rand64(), rand64(), 3'($urandom));
    end else begin
      // Load close to the top so increments wrap the counter.
      load({{3{64'hFFFFFFFFFFFFFFFF}}, 64'hFFFFFFFFFFFFFFFF - 64'($urandom_range(3))},
           3'($urandom));
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_GEN;
    in_ch.skip_count = '0;
    in_ch.position_word_0 = '0;
    in_ch.position_word_1 = '0;
    in_ch.position_word_2 = '0;
    in_ch.position_word_3 = '0;
    in_ch.start_slot = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset key stream, block crossings, skip corners, wrap, ignored opcode.
    gen(9);
    skip(64'd0);
    skip(64'd0);
    gen(1);
    skip(64'd3);
    gen(1);
    skip(64'd8);
    gen(1);
    skip(64'hFFFFFFFFFFFFFFFF);
    gen(1);
    load({256{1'b1}}, 3'd7);
    gen(2);
    load('0, 3'd0);
    send(OpUnused, '1, '1, '1, '1, '1, 3'd7);
    gen(1);
    skip(64'd13);
    gen(1);

    // Ignored index, then extreme keys on every register.
    write_key(CfgIdxUnused, rand64());
    for (int i = 0; i < KeyCount; i++) write_key(CfgIdxW'(i), '0);
    gen(3);
    for (int i = 0; i < KeyCount; i++) write_key(CfgIdxW'(i), '1);
    gen(3);

    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 35 : (ph == 1) ? 83 : 0;
      rcv_idle = (ph == 0) ? 83 : (ph == 1) ? 35 : 0;
      for (int i = 0; i < KeyCount; i++)
        write_key(CfgIdxW'(i), (ph == 2 && i == 0) ? 64'hDEADBEEFDEADBEEF : rand64());
      for (int i = 0; i < ItemsPerPhase; i++) begin
        // Hold the sender once until all words are back.
        if (ph == 0 && i == ItemsPerPhase / 2) drain();
        random_request();
      end
    end

    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
